FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the heading servo design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define GHS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, checked on every rising edge out of reset
`define GHS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

FILE: design/ghs_pkg.sv
// ----------------------------------------------------------------------------
// ghs_pkg
// Widths, codes and shared types of the heading servo controller.
// ----------------------------------------------------------------------------
package ghs_pkg;

    // field and datapath widths
    localparam int RATE_W     = 21;   // offset-corrected rate, signed
    localparam int ACC_W      = 48;   // heading accumulator, signed
    localparam int OPA_W      = 29;   // multiplicand of the serial multiplier, signed
    localparam int OPB_W      = 20;   // multiplier bits, unsigned
    localparam int QUO_W      = 28;   // magnitude of heading_acc / 1e6
    localparam int REM_W      = ACC_W - QUO_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);
    localparam int OUT_W      = 32;   // heading and drive ports
    localparam int ANGLE_W    = 8;
    localparam int TIME_W     = 24;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // divisor from micro-units to Q8 degrees
    localparam logic [REM_W-1:0] US_PER_S = REM_W'(1000000);

    // accumulator saturation limits
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // drive saturation limits
    localparam logic [OUT_W-1:0] DRIVE_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] DRIVE_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // servo angles in degrees
    localparam logic [ANGLE_W-1:0] ANG_A_RESET  = 8'd90;
    localparam logic [ANGLE_W-1:0] ANG_B_RESET  = 8'd70;
    localparam logic [ANGLE_W-1:0] ANG_ZERO     = 8'd0;
    localparam logic [ANGLE_W-1:0] ANG_MAX      = 8'd180;
    localparam logic [ANGLE_W-1:0] ANG_DEPLOY_B = 8'd160;
    localparam logic [ANGLE_W-1:0] ANG_END_A    = 8'd150;
    localparam logic [ANGLE_W-1:0] ANG_END_B    = 8'd10;

    // servo B bias in Q8: 160 degrees
    localparam logic [OUT_W:0] B_BIAS_Q8 = 33'd40960;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] RATE_OFFSET_RESET = 20'd58;
    localparam logic [GAIN_W-1:0]     PROP_GAIN_RESET   = 16'd26;
    localparam logic [GAIN_W-1:0]     INTEG_GAIN_RESET  = 16'd13;
    localparam logic [GAIN_W-1:0]     HOLD_TIME_RESET   = 16'd8000;
    localparam logic [GAIN_W-1:0]     DEPLOY_TIME_RESET = 16'd4000;
    localparam logic [GAIN_W-1:0]     CONTROL_END_RESET = 16'd5500;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENSOR_OK,
        REG_RATE_OFFSET,
        REG_PROP_GAIN,
        REG_INTEG_GAIN,
        REG_HOLD_TIME,
        REG_DEPLOY_TIME,
        REG_CONTROL_END
    } reg_index_t;

    // flight phases
    typedef enum logic [1:0] {
        PH_HOLD,
        PH_DEPLOY,
        PH_CONTROL,
        PH_END
    } phase_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_DT,
        ST_ACCUM,
        ST_DIV_P,
        ST_MUL_I,
        ST_DRIVE,
        ST_FINISH
    } ctrl_state_t;

    // job request to the serial multiplier
    typedef struct packed {
        logic             start;
        logic [OPA_W-1:0] a;      // signed multiplicand
        logic [OPB_W-1:0] b;      // unsigned multiplier
        logic [ACC_W-1:0] init;   // signed starting sum
    } mac_req_t;

endpackage

FILE: design/ghs_div.sv
// ----------------------------------------------------------------------------
// ghs_div
// Bit-serial signed divide of the heading accumulator by one million.
// ----------------------------------------------------------------------------
module ghs_div
    import ghs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [ACC_W-1:0] dividend,
    output logic             busy,
    output logic [QUO_W:0]   quotient
);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] q_reg, q_next;
    logic             neg_reg, neg_next;
    logic [ACC_W-1:0] mag;
    logic [REM_W:0]   trial;
    logic             ge;

    // magnitude of the dividend and one restoring step
    always_comb
    begin
        mag   = dividend[ACC_W-1] ? (~dividend + 1'b1) : dividend;
        trial = {rem_reg, q_reg[QUO_W-1]};
        ge    = (trial >= {1'b0, US_PER_S});
    end

    // step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_STEPS);
            rem_next  = mag[ACC_W-1:QUO_W];
            q_next    = mag[QUO_W-1:0];
            neg_next  = dividend[ACC_W-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                rem_next = ge ? REM_W'(trial - {1'b0, US_PER_S}) : trial[REM_W-1:0];
                q_next   = {q_reg[QUO_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    // truncation toward zero: negate the magnitude quotient
    assign busy     = busy_reg;
    assign quotient = neg_reg ? (~{1'b0, q_reg} + 1'b1) : {1'b0, q_reg};

endmodule

FILE: design/ghs_mac.sv
// ----------------------------------------------------------------------------
// ghs_mac
// Shift-add multiply-accumulate, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module ghs_mac
    import ghs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mac_req_t         req,
    output logic             busy,
    output logic [ACC_W-1:0] result
);

    logic             busy_reg, busy_next;
    logic [ACC_W-1:0] a_reg, a_next;
    logic [OPB_W-1:0] b_reg, b_next;
    logic [ACC_W-1:0] acc_reg, acc_next;

    // shift the multiplicand up and the multiplier down, stop once no bits remain
    always_comb
    begin
        busy_next = busy_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            a_next    = {{(ACC_W-OPA_W){req.a[OPA_W-1]}}, req.a};
            b_next    = req.b;
            acc_next  = req.init;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = {a_reg[ACC_W-2:0], 1'b0};
                b_next = {1'b0, b_reg[OPB_W-1:1]};
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign busy   = busy_reg;
    assign result = acc_reg;

endmodule

FILE: design/gyro_heading_servo_controller.sv
// ----------------------------------------------------------------------------
// gyro_heading_servo_controller
// PI heading-hold controller driving two yaw servos from gyro rate samples.
// ----------------------------------------------------------------------------
// One item at a time: a new sample is taken only in the idle state. The
// bit-serial multiplier steps once per significant bit of delta_us, then
// once per bit of prop_gain (overlapped with the divider) and of
// integ_gain; the heading divide by one million always runs 28 steps.
// A finished result sits in the output register while the next sample is
// taken; the block stalls at its last step only if that result is still
// waiting. Configuration writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gyro_heading_servo_controller
    import ghs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // sample channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [19:0]           gyro_rate,
    input  logic [19:0]           delta_us,
    input  logic [TIME_W-1:0]     elapsed_ms,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ANGLE_W-1:0]    servo_a_angle,
    output logic [ANGLE_W-1:0]    servo_b_angle,
    output logic [1:0]            phase,
    output logic [OUT_W-1:0]      heading,
    output logic [OUT_W-1:0]      drive
);

    ctrl_state_t state_reg, state_next;

    // configuration registers
    logic                  sensor_ok_reg;
    logic [CFG_DATA_W-1:0] rate_offset_reg;
    logic [GAIN_W-1:0]     prop_gain_reg;
    logic [GAIN_W-1:0]     integ_gain_reg;
    logic [GAIN_W-1:0]     hold_time_reg;
    logic [GAIN_W-1:0]     deploy_time_reg;
    logic [GAIN_W-1:0]     control_end_reg;

    // working registers
    logic [RATE_W-1:0]  rate_reg;
    logic [TIME_W-1:0]  t_reg;
    logic [ACC_W-1:0]   heading_acc_reg;
    logic [OPA_W-1:0]   heading_reg;
    logic [OUT_W-1:0]   drive_reg;
    phase_t             phase_reg;
    logic [ANGLE_W-1:0] last_a_reg, last_a_next;
    logic [ANGLE_W-1:0] last_b_reg, last_b_next;

    // output registers
    logic               out_valid_reg;
    logic [ANGLE_W-1:0] out_a_reg;
    logic [ANGLE_W-1:0] out_b_reg;
    phase_t             out_phase_reg;
    logic [OUT_W-1:0]   out_heading_reg;
    logic [OUT_W-1:0]   out_drive_reg;

    // datapath signals
    logic [RATE_W-1:0] rate_in;
    logic [ACC_W:0]    acc_sum;
    logic [ACC_W-1:0]  acc_sat;
    logic [OUT_W-1:0]  drive_sat;
    logic [16:0]       deploy_limit;
    logic [16:0]       control_limit;
    phase_t            phase_calc;
    logic [OUT_W:0]    b_sum;

    // unit interfaces and sequencer outputs
    mac_req_t          mac_req;
    logic              mac_busy;
    logic [ACC_W-1:0]  mac_result;
    logic              div_start;
    logic              div_busy;
    logic [QUO_W:0]    div_quo;
    logic              in_accept;
    logic              acc_load;
    logic              head_load;
    logic              drive_load;
    logic              out_load;

    ghs_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mac_req),
        .busy   (mac_busy),
        .result (mac_result)
    );

    ghs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_sat),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // offset-corrected rate, zero when the sensor is flagged bad
    always_comb
    begin
        if (sensor_ok_reg)
        begin
            rate_in = {gyro_rate[19], gyro_rate} - {rate_offset_reg[19], rate_offset_reg};
        end
        else
        begin
            rate_in = '0;
        end
    end

    // heading accumulate with saturation to the accumulator range
    always_comb
    begin
        acc_sum = {heading_acc_reg[ACC_W-1], heading_acc_reg}
                + {mac_result[ACC_W-1], mac_result};
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
        begin
            acc_sat = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    // drive is the Q8 sum shifted down by 8 (floor) and clamped to 32 bits
    always_comb
    begin
        if ((mac_result[ACC_W-1:OUT_W+7] == '0)
            || (mac_result[ACC_W-1:OUT_W+7] == '1))
        begin
            drive_sat = mac_result[OUT_W+7:8];
        end
        else
        begin
            drive_sat = mac_result[ACC_W-1] ? DRIVE_MIN : DRIVE_MAX;
        end
    end

    // phase from elapsed time
    always_comb
    begin
        deploy_limit  = {1'b0, hold_time_reg} + {1'b0, deploy_time_reg};
        control_limit = {1'b0, hold_time_reg} + {1'b0, control_end_reg};
        priority if (t_reg < TIME_W'(hold_time_reg))
        begin
            phase_calc = PH_HOLD;
        end
        else if (t_reg < TIME_W'(deploy_limit))
        begin
            phase_calc = PH_DEPLOY;
        end
        else if (t_reg < TIME_W'(control_limit))
        begin
            phase_calc = PH_CONTROL;
        end
        else
        begin
            phase_calc = PH_END;
        end
    end

    // servo commands for the current phase
    always_comb
    begin
        b_sum = B_BIAS_Q8 + {drive_reg[OUT_W-1], drive_reg};
        unique case (phase_reg)
            PH_HOLD:
            begin
                last_a_next = last_a_reg;
                last_b_next = last_b_reg;
            end
            PH_DEPLOY:
            begin
                last_a_next = ANG_ZERO;
                last_b_next = ANG_DEPLOY_B;
            end
            PH_CONTROL:
            begin
                if (!drive_reg[OUT_W-1] && (drive_reg != '0))
                begin
                    if (drive_reg[OUT_W-2:8] > (OUT_W-9)'(ANG_MAX))
                    begin
                        last_a_next = ANG_MAX;
                    end
                    else
                    begin
                        last_a_next = drive_reg[15:8];
                    end
                    last_b_next = ANG_MAX;
                end
                else
                begin
                    last_a_next = ANG_ZERO;
                    if (!b_sum[OUT_W] && (b_sum != '0))
                    begin
                        last_b_next = b_sum[15:8];
                    end
                    else
                    begin
                        last_b_next = ANG_ZERO;
                    end
                end
            end
            PH_END:
            begin
                last_a_next = ANG_END_A;
                last_b_next = ANG_END_B;
            end
            default:
            begin
                last_a_next = last_a_reg;
                last_b_next = last_b_reg;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL_DT;
                end
            end
            ST_MUL_DT:
            begin
                if (!mac_busy)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                state_next = ST_DIV_P;
            end
            ST_DIV_P:
            begin
                if (!mac_busy && !div_busy)
                begin
                    state_next = ST_MUL_I;
                end
            end
            ST_MUL_I:
            begin
                if (!mac_busy)
                begin
                    state_next = ST_DRIVE;
                end
            end
            ST_DRIVE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready   = 1'b0;
        mac_req    = '0;
        div_start  = 1'b0;
        acc_load   = 1'b0;
        head_load  = 1'b0;
        drive_load = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                mac_req.start = in_valid;
                mac_req.a     = {{(OPA_W-RATE_W){rate_in[RATE_W-1]}}, rate_in};
                mac_req.b     = delta_us;
            end
            ST_ACCUM:
            begin
                acc_load      = 1'b1;
                div_start     = 1'b1;
                mac_req.start = 1'b1;
                mac_req.a     = {{(OPA_W-RATE_W){rate_reg[RATE_W-1]}}, rate_reg};
                mac_req.b     = {{(OPB_W-GAIN_W){1'b0}}, prop_gain_reg};
            end
            ST_DIV_P:
            begin
                if (!mac_busy && !div_busy)
                begin
                    head_load     = 1'b1;
                    mac_req.start = 1'b1;
                    mac_req.a     = div_quo;
                    mac_req.b     = {{(OPB_W-GAIN_W){1'b0}}, integ_gain_reg};
                    mac_req.init  = mac_result;
                end
            end
            ST_DRIVE:
            begin
                drive_load = 1'b1;
            end
            ST_FINISH:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_accept = in_valid && in_ready;

    // control state, configuration and persistent values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            sensor_ok_reg   <= 1'b1;
            rate_offset_reg <= RATE_OFFSET_RESET;
            prop_gain_reg   <= PROP_GAIN_RESET;
            integ_gain_reg  <= INTEG_GAIN_RESET;
            hold_time_reg   <= HOLD_TIME_RESET;
            deploy_time_reg <= DEPLOY_TIME_RESET;
            control_end_reg <= CONTROL_END_RESET;
            heading_acc_reg <= '0;
            last_a_reg      <= ANG_A_RESET;
            last_b_reg      <= ANG_B_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SENSOR_OK:   sensor_ok_reg   <= cfg_data[0];
                    REG_RATE_OFFSET: rate_offset_reg <= cfg_data;
                    REG_PROP_GAIN:   prop_gain_reg   <= cfg_data[GAIN_W-1:0];
                    REG_INTEG_GAIN:  integ_gain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_HOLD_TIME:   hold_time_reg   <= cfg_data[GAIN_W-1:0];
                    REG_DEPLOY_TIME: deploy_time_reg <= cfg_data[GAIN_W-1:0];
                    REG_CONTROL_END: control_end_reg <= cfg_data[GAIN_W-1:0];
                    default:         sensor_ok_reg   <= sensor_ok_reg;
                endcase
            end
            if (acc_load)
            begin
                heading_acc_reg <= acc_sat;
            end
            if (out_load)
            begin
                last_a_reg    <= last_a_next;
                last_b_reg    <= last_b_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rate_reg <= rate_in;
            t_reg    <= elapsed_ms;
        end
        if (head_load)
        begin
            heading_reg <= div_quo;
        end
        if (drive_load)
        begin
            drive_reg <= drive_sat;
            phase_reg <= phase_calc;
        end
        if (out_load)
        begin
            out_a_reg       <= last_a_next;
            out_b_reg       <= last_b_next;
            out_phase_reg   <= phase_reg;
            out_heading_reg <= {{(OUT_W-OPA_W){heading_reg[OPA_W-1]}}, heading_reg};
            out_drive_reg   <= drive_reg;
        end
    end

    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign servo_a_angle = out_a_reg;
    assign servo_b_angle = out_b_reg;
    assign phase         = out_phase_reg;
    assign heading       = out_heading_reg;
    assign drive         = out_drive_reg;

    // checks
    `GHS_ASSERT_IMP(a_idle_units_free, in_ready, !mac_busy && !div_busy)
    `GHS_ASSERT_NXT(a_accept_starts_mul, in_accept, (state_reg == ST_MUL_DT) && mac_busy)
    `GHS_ASSERT_NXT(a_result_waits, (state_reg == ST_FINISH) && out_valid && !out_ready, state_reg == ST_FINISH)
    `GHS_ASSERT_IMP(a_angle_range, out_valid, (servo_a_angle <= ANG_MAX) && (servo_b_angle <= ANG_MAX))

endmodule
